// ===== design/tid_pkg.sv =====
// ============================================================================
// tid_pkg
// Shared types and constants for the timed input debouncer.
// ============================================================================
`default_nettype none

package tid_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int CHANNEL_W        = 4;
    localparam int TIME_W           = 32;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 2'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [CFG_W-1:0] INVERT_RESET   = 16'd0;

    // Per-channel state word held in the channel memory
    typedef struct packed {
        logic              pending_level;
        logic [TIME_W-1:0] pending_since;
        logic              stable_level;
        logic              change_flag;
        logic [TIME_W-1:0] last_change_time;
        logic [TIME_W-1:0] last_interval;
    } tid_entry_t;

    localparam int ENTRY_W = $bits(tid_entry_t);

endpackage

`default_nettype wire

// ===== design/timed_input_debouncer.sv =====
// ============================================================================
// timed_input_debouncer
// Multi-channel debouncer with per-channel state in one memory.
// ============================================================================
//
//  channel   direction  handshake             beat contents
//  s_        in         s_valid / s_ready     channel, raw level, time in ms
//  m_        out        m_valid / m_ready     channel, stable level, change, interval
//  cfg_      in         cfg_valid / cfg_ready register index, write data
//
//  One beat per cycle sustained while the m_ side does not stall; a result
//  passes through the update stage and then the output register. The memory
//  is read in the accept cycle ahead of one update-and-write stage; a write to
//  the channel read in the same cycle is forwarded. Reset is synchronous;
//  per-channel valid bits make all channels read as zero at once, so no
//  clearing pass is needed. A stalled m_ side holds one result in the output
//  register and one item in the update stage; s_ready drops only then.
// ============================================================================
`default_nettype none

module timed_input_debouncer #(
    parameter int NUM_CHANNELS = tid_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [tid_pkg::CHANNEL_W-1:0]  s_channel,
    input  wire logic                           s_raw_level,
    input  wire logic [tid_pkg::TIME_W-1:0]     s_now_ms,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [tid_pkg::CHANNEL_W-1:0]  m_out_channel,
    output logic                                m_stable_level,
    output logic                                m_changed,
    output logic      [tid_pkg::TIME_W-1:0]     m_interval_ms,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tid_pkg::CFG_W-1:0]      cfg_data
);

    import tid_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EXT_W = 9;

    // Configuration registers
    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] invert_reg;

    // Update stage
    logic                 s1_valid_reg;
    logic [CHANNEL_W-1:0] s1_channel_reg;
    logic                 s1_level_reg;
    logic [TIME_W-1:0]    s1_now_reg;
    logic                 s1_in_range_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic                 s1_entry_valid_reg;
    logic                 fwd_hit_reg;
    tid_entry_t           fwd_data_reg;

    // Output register
    logic                 m_valid_reg;
    logic [CHANNEL_W-1:0] m_channel_reg;
    logic                 m_stable_reg;
    logic                 m_changed_reg;
    logic [TIME_W-1:0]    m_interval_reg;

    logic [NUM_CHANNELS-1:0] entry_valid_reg;

    logic [EXT_W-1:0]   ch_ext;
    logic [IDX_W-1:0]   in_idx;
    logic               in_range;
    logic               accept;
    logic               advance;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    tid_entry_t         cur_entry;
    tid_entry_t         entry_next;
    logic               level;
    logic [TIME_W-1:0]  elapsed;

    assign ch_ext   = {{(EXT_W - CHANNEL_W){1'b0}}, s_channel};
    assign in_idx   = ch_ext[IDX_W-1:0];
    assign in_range = (ch_ext < EXT_W'(NUM_CHANNELS));

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign ram_we  = advance && s1_in_range_reg;

    assign cfg_ready = 1'b1;

    tid_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CHANNELS),
        .ADDR_W(IDX_W)
    ) u_state_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(s1_idx_reg),
        .wdata(entry_next),
        .re   (accept && in_range),
        .raddr(in_idx),
        .rdata(ram_rdata)
    );

    // Entries never written since reset read as all zero.
    always_comb begin
        if (fwd_hit_reg) begin
            cur_entry = fwd_data_reg;
        end else if (s1_entry_valid_reg) begin
            cur_entry = tid_entry_t'(ram_rdata);
        end else begin
            cur_entry = '0;
        end
    end

    assign level   = s1_level_reg ^ invert_reg[s1_channel_reg];
    assign elapsed = s1_now_reg - cur_entry.pending_since;

    always_comb begin
        entry_next = cur_entry;
        if (level != cur_entry.pending_level) begin
            entry_next.pending_level = level;
            entry_next.pending_since = s1_now_reg;
        end else begin
            entry_next.change_flag = 1'b0;
            if ((elapsed > {{(TIME_W - CFG_W){1'b0}}, debounce_reg}) &&
                (level != cur_entry.stable_level)) begin
                entry_next.change_flag      = 1'b1;
                entry_next.stable_level     = level;
                entry_next.last_interval    = s1_now_reg - cur_entry.last_change_time;
                entry_next.last_change_time = s1_now_reg;
            end
        end
    end

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            invert_reg   <= INVERT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data;
                REG_INVERT:   invert_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            entry_valid_reg <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (ram_we) begin
                entry_valid_reg[s1_idx_reg] <= 1'b1;
            end
        end
    end

    // Update stage payload. A write leaving the stage in the same cycle as a
    // read of the same channel is captured for the incoming item.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_channel_reg     <= s_channel;
            s1_level_reg       <= s_raw_level;
            s1_now_reg         <= s_now_ms;
            s1_in_range_reg    <= in_range;
            s1_idx_reg         <= in_idx;
            s1_entry_valid_reg <= in_range ? entry_valid_reg[in_idx] : 1'b0;
            fwd_hit_reg        <= ram_we && (s1_idx_reg == in_idx);
            fwd_data_reg       <= entry_next;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_channel_reg <= s1_channel_reg;
            if (s1_in_range_reg) begin
                m_stable_reg   <= entry_next.stable_level;
                m_changed_reg  <= entry_next.change_flag;
                m_interval_reg <= entry_next.last_interval;
            end else begin
                m_stable_reg   <= 1'b0;
                m_changed_reg  <= 1'b0;
                m_interval_reg <= '0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_channel  = m_channel_reg;
    assign m_stable_level = m_stable_reg;
    assign m_changed      = m_changed_reg;
    assign m_interval_ms  = m_interval_reg;

endmodule

`default_nettype wire

// ===== design/tid_ram.sv =====
// ============================================================================
// tid_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module tid_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/tid_checker.sv =====
// ============================================================================
// tid_checker
// Port-level checks on the timed input debouncer, bound to the top level.
// ============================================================================
`default_nettype none

module tid_checker #(
    parameter int NUM_CHANNELS = tid_pkg::NUM_CHANNELS_DEF
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [tid_pkg::CHANNEL_W-1:0] m_out_channel,
    input wire logic                          m_stable_level,
    input wire logic                          m_changed,
    input wire logic [tid_pkg::TIME_W-1:0]    m_interval_ms
);

    import tid_pkg::*;

    localparam int EXT_W = 9;

    logic [EXT_W-1:0] out_ch_ext;

    assign out_ch_ext = {{(EXT_W - CHANNEL_W){1'b0}}, m_out_channel};

    // A result beat that is not taken stays on the port.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_channel) &&
                                   $stable(m_interval_ms) && $stable(m_changed)))
        else $error("result beat dropped or changed while stalled");

    // No result is offered right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Input back-pressure only comes from a stalled result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a stalled result");

    // A channel outside the configured set reports all zeros.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (out_ch_ext >= EXT_W'(NUM_CHANNELS))) |->
            (!m_stable_level && !m_changed && (m_interval_ms == '0)))
        else $error("unused channel reported nonzero state");

endmodule

bind timed_input_debouncer tid_checker #(
    .NUM_CHANNELS(NUM_CHANNELS)
) u_tid_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_channel (m_out_channel),
    .m_stable_level(m_stable_level),
    .m_changed     (m_changed),
    .m_interval_ms (m_interval_ms)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the timed input debouncer. A short table of
// directed samples is followed by phases of random, bouncing pin samples
// under several delay and polarity settings and handshake idling patterns.
// Every result beat is scored field by field against an in-bench model or a typed-in result.
// ============================================================================

module testbench;
    import tid_pkg::*;

    localparam int NUM_CH          = NUM_CHANNELS_DEF;
    localparam int RST_CYCLES      = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PRESSURE_ITEMS  = 40;
    localparam int PRESSURE_PHASE  = 2;
    localparam int SETTLE_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int NUM_PHASES      = 6;
    localparam int NUM_DIR_ROWS    = 24;

    typedef struct packed {
        logic [CHANNEL_W-1:0] ch;
        logic                 stable;
        logic                 changed;
        logic [TIME_W-1:0]    gap;
    } deb_result_t;

    // A directed row may carry a typed-in result that replaces the model's.
    typedef struct packed {
        logic        typed;
        deb_result_t res;
    } pinned_res_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] ch;
        logic                 raw;
        logic [TIME_W-1:0]    now;
        logic                 typed;
        logic                 x_stable;
        logic                 x_changed;
        logic [TIME_W-1:0]    x_gap;
    } dir_row_t;

    typedef struct {
        logic [CFG_W-1:0]  deb;
        logic [CFG_W-1:0]  inv;
        int                src_pct;
        int                sink_pct;
        int                items;
        logic [TIME_W-1:0] tick0;
    } run_phase_t;

    localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
        // Right after reset every channel reads as zero.
        '{4'd0,  1'b0, 32'd0,          1'b1, 1'b0, 1'b0, 32'd0},
        '{4'd0,  1'b1, 32'd100,        1'b1, 1'b0, 1'b0, 32'd0},
        // Held for exactly the delay, which is not enough.
        '{4'd0,  1'b1, 32'd120,        1'b1, 1'b0, 1'b0, 32'd0},
        // First accepted change: interval counts from time zero.
        '{4'd0,  1'b1, 32'd121,        1'b1, 1'b1, 1'b1, 32'd121},
        '{4'd0,  1'b1, 32'd122,        1'b1, 1'b1, 1'b0, 32'd121},
        '{4'd15, 1'b1, 32'hFFFF_FFF0,  1'b1, 1'b0, 1'b0, 32'd0},
        // The hold spans the wrap of the millisecond counter.
        '{4'd15, 1'b1, 32'h0000_0005,  1'b1, 1'b1, 1'b1, 32'd5},
        // A new pending level leaves the change flag as it was.
        '{4'd15, 1'b0, 32'd6,          1'b1, 1'b1, 1'b1, 32'd5},
        '{4'd15, 1'b1, 32'd7,          1'b1, 1'b1, 1'b1, 32'd5},
        '{4'd15, 1'b1, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd7,  1'b1, 32'd200,        1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd7,  1'b0, 32'd210,        1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd7,  1'b0, 32'd240,        1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd0,  1'b0, 32'd200,        1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd0,  1'b0, 32'd221,        1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd8,  1'b1, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd8,  1'b1, 32'h0000_0014,  1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd3,  1'b1, 32'd50,         1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd3,  1'b1, 32'd71,         1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd3,  1'b0, 32'd80,         1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd3,  1'b1, 32'd90,         1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd3,  1'b1, 32'd111,        1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd12, 1'b1, 32'd0,          1'b0, 1'b0, 1'b0, 32'd0},
        '{4'd12, 1'b1, 32'd21,         1'b0, 1'b0, 1'b0, 32'd0}
    };

    run_phase_t phases [NUM_PHASES] = '{
        '{16'd0,     16'hFFFF, 0,  0,  260, 32'd0},
        '{16'd65535, 16'h5A3C, 71, 0,  260, 32'hFFF8_0000},
        '{16'd7,     16'h00FF, 0,  71, 260, 32'd1000},
        '{16'd0,     16'h0000, 23, 23, 260, 32'd0},
        '{16'd20,    16'h0000, 23, 23, 260, 32'h7FFF_FF00},
        '{16'd300,   16'h0F0F, 0,  0,  260, 32'd0}
    };

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [CHANNEL_W-1:0] s_channel   = '0;
    logic                 s_raw_level = 1'b0;
    logic [TIME_W-1:0]    s_now_ms    = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [CHANNEL_W-1:0] m_out_channel;
    logic                 m_stable_level;
    logic                 m_changed;
    logic [TIME_W-1:0]    m_interval_ms;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;

    // Model copy of the registers and the per-channel filter state.
    logic [CFG_W-1:0]  hold_ms  = DEBOUNCE_RESET;
    logic [CFG_W-1:0]  inv_mask = INVERT_RESET;
    logic              pend_lvl   [NUM_CH];
    logic [TIME_W-1:0] pend_t0    [NUM_CH];
    logic              stable_lvl [NUM_CH];
    logic              chg_flag   [NUM_CH];
    logic [TIME_W-1:0] last_chg_t [NUM_CH];
    logic [TIME_W-1:0] last_gap   [NUM_CH];

    deb_result_t awaited_q [$];
    pinned_res_t pinned_q [$];
    logic        failed = 1'b0;

    int                src_idle_pct   = 0;
    int                sink_stall_pct = 0;
    logic              line_lvl [NUM_CH];
    logic [TIME_W-1:0] tick = '0;

    int hold_reqs   = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int quiet_count = 0;

    timed_input_debouncer #(
        .NUM_CHANNELS (NUM_CH)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_channel      (s_channel),
        .s_raw_level    (s_raw_level),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_channel  (m_out_channel),
        .m_stable_level (m_stable_level),
        .m_changed      (m_changed),
        .m_interval_ms  (m_interval_ms),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic deb_result_t debounce_sample(input logic [CHANNEL_W-1:0] ch,
                                                    input logic raw,
                                                    input logic [TIME_W-1:0] now);
        deb_result_t       r;
        logic              lvl;
        logic [TIME_W-1:0] held;
        r = '0;
        r.ch = ch;
        if (ch >= NUM_CH)
            return r;
        lvl = raw ^ inv_mask[ch];
        if (lvl != pend_lvl[ch]) begin
            pend_lvl[ch] = lvl;
            pend_t0[ch] = now;
        end else begin
            chg_flag[ch] = 1'b0;
            held = now - pend_t0[ch];
            if (held > TIME_W'(hold_ms) && lvl != stable_lvl[ch]) begin
                chg_flag[ch] = 1'b1;
                stable_lvl[ch] = lvl;
                last_gap[ch] = now - last_chg_t[ch];
                last_chg_t[ch] = now;
            end
        end
        r.stable = stable_lvl[ch];
        r.changed = chg_flag[ch];
        r.gap = last_gap[ch];
        return r;
    endfunction

    // Input beats feed the model; result beats are scored against its output.
    always @(posedge aclk) begin
        pinned_res_t pin;
        deb_result_t want;
        if (aresetn && s_valid && s_ready) begin
            pin = pinned_q.pop_front();
            want = debounce_sample(s_channel, s_raw_level, s_now_ms);
            if (pin.typed)
                want = pin.res;
            awaited_q.push_back(want);
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_q.size() == 0) begin
                $error("result beat for channel %0d with nothing awaited", m_out_channel);
                failed = 1'b1;
            end else begin
                want = awaited_q.pop_front();
                if (m_out_channel !== want.ch) begin
                    $error("out_channel: expected %0d, got %0d", want.ch, m_out_channel);
                    failed = 1'b1;
                end
                if (m_stable_level !== want.stable) begin
                    $error("stable_level: expected %0d, got %0d", want.stable, m_stable_level);
                    failed = 1'b1;
                end
                if (m_changed !== want.changed) begin
                    $error("changed: expected %0d, got %0d", want.changed, m_changed);
                    failed = 1'b1;
                end
                if (m_interval_ms !== want.gap) begin
                    $error("interval_ms: expected %0d, got %0d", want.gap, m_interval_ms);
                    failed = 1'b1;
                end
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_OFF_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_count <= 0;
        end else if (quiet_count == WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    task automatic send_sample(input logic [CHANNEL_W-1:0] ch, input logic raw,
                               input logic [TIME_W-1:0] now, input pinned_res_t pin);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        pinned_q.push_back(pin);
        s_valid <= 1'b1;
        s_channel <= ch;
        s_raw_level <= raw;
        s_now_ms <= now;
        do @(posedge aclk); while (!s_ready);
    endtask

    // A pin that mostly holds its level, bounces now and then, and is
    // sampled on a handful of busy channels more often than the rest.
    task automatic send_bouncy_sample(input int span);
        logic [CHANNEL_W-1:0] ch;
        logic                 raw;
        logic [TIME_W-1:0]    now;
        if ($urandom_range(0, 99) < 60)
            ch = CHANNEL_W'($urandom_range(0, 3));
        else
            ch = CHANNEL_W'($urandom_range(0, NUM_CH - 1));
        if ($urandom_range(0, 99) < 4)
            line_lvl[ch] = ~line_lvl[ch];
        raw = line_lvl[ch] ^ ($urandom_range(0, 99) < 15);
        tick = tick + $urandom_range(0, span);
        now = ($urandom_range(0, 99) < 3) ? TIME_W'($urandom) : tick;
        send_sample(ch, raw, now, '0);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_q.size() != 0 || pinned_q.size() != 0);
    endtask

    task automatic configure(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] inv);
        cfg_valid <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_data <= deb;
        do @(posedge aclk); while (!cfg_ready);
        hold_ms = deb;
        cfg_index <= REG_INVERT;
        cfg_data <= inv;
        do @(posedge aclk); while (!cfg_ready);
        inv_mask = inv;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        pinned_res_t pin;
        int          span;
        for (int k = 0; k < NUM_CH; k++) begin
            pend_lvl[k] = 1'b0;
            pend_t0[k] = '0;
            stable_lvl[k] = 1'b0;
            chg_flag[k] = 1'b0;
            last_chg_t[k] = '0;
            last_gap[k] = '0;
            line_lvl[k] = 1'b0;
        end
        phases[3].deb = CFG_W'($urandom_range(1, 2000));
        phases[3].inv = CFG_W'($urandom);
        phases[3].tick0 = $urandom;

        repeat (RST_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[i]) begin
            pin.typed = DIR_ROWS[i].typed;
            pin.res = '{ch: DIR_ROWS[i].ch, stable: DIR_ROWS[i].x_stable,
                        changed: DIR_ROWS[i].x_changed, gap: DIR_ROWS[i].x_gap};
            send_sample(DIR_ROWS[i].ch, DIR_ROWS[i].raw, DIR_ROWS[i].now, pin);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            configure(phases[p].deb, phases[p].inv);
            src_idle_pct = phases[p].src_pct;
            sink_stall_pct = phases[p].sink_pct;
            tick = phases[p].tick0;
            span = phases[p].deb / 6 + 2;
            for (int n = 0; n < phases[p].items; n++) begin
                if (p == PRESSURE_PHASE && n == phases[p].items / 3) begin
                    // Block the result side and keep offering beats back to back.
                    hold_reqs <= hold_reqs + 1;
                    src_idle_pct = 0;
                    repeat (PRESSURE_ITEMS) send_bouncy_sample(span);
                    src_idle_pct = phases[p].src_pct;
                end
                if (p == PRESSURE_PHASE && n == 2 * phases[p].items / 3)
                    drain_results();
                send_bouncy_sample(span);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (!failed)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
